>>> rtl/core/ectt_pkg.sv
package ectt_pkg;

	// Event codes carried by the request opcode.
	typedef enum logic [1:0] {
		OP_PULSE   = 2'd0,
		OP_POLL    = 2'd1,
		OP_CONSUME = 2'd2
	} op_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_GLITCH  = 3'd0,
		CFG_TIMEOUT = 3'd1,
		CFG_MAX_PND = 3'd2,
		CFG_ALPHA   = 3'd3,
		CFG_PPQ     = 3'd4
	} cfg_idx_t;

	// Sequencer states of the top level.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAP,
		ST_EXEC,
		ST_MUL_WAIT,
		ST_BLEND,
		ST_DVS,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_TEMPO,
		ST_TIMEOUT,
		ST_OUT
	} state_t;

	// Operations of the shared arithmetic unit.
	typedef enum logic {
		ALU_MUL = 1'b0,
		ALU_DIV = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam int unsigned ALPHA_W = 17;
	localparam int unsigned MAG_W = 32;
	localparam int unsigned PROD_W = ALPHA_W + MAG_W;
	localparam int unsigned DVS_W = 39;
	localparam int unsigned QUO_W = 34;
	localparam int unsigned ADD_W = 50;
	localparam int unsigned CNT_W = 6;

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(ALPHA_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

	// Sixty million microseconds times 256.
	localparam logic [QUO_W-1:0] TEMPO_NUM = 34'd15360000000;
	localparam logic [23:0] TEMPO_MAX = 24'hFFFFFF;

	localparam logic [31:0] GLITCH_RST = 32'd1000;
	localparam logic [31:0] TIMEOUT_RST = 32'd2000000;
	localparam logic [7:0] MAX_PND_RST = 8'd8;
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd6554;
	localparam logic [6:0] PPQ_RST = 7'd4;

endpackage

>>> rtl/core/ectt_in_if.sv
interface ectt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [63:0] now_us;

	modport source (output valid, output opcode, output now_us, input ready);
	modport sink (input valid, input opcode, input now_us, output ready);
endinterface

>>> rtl/core/ectt_out_if.sv
interface ectt_out_if;
	logic        valid;
	logic        ready;
	logic        tick_granted;
	logic        ext_sync;
	logic [31:0] period_us;
	logic [23:0] bpm_q8;
	logic [7:0]  pending_ticks;

	modport source (output valid, output tick_granted, output ext_sync, output period_us,
		output bpm_q8, output pending_ticks, input ready);
	modport sink (input valid, input tick_granted, input ext_sync, input period_us,
		input bpm_q8, input pending_ticks, output ready);
endinterface

>>> rtl/core/external_clock_tempo_tracker_top.sv
// External clock tempo tracker. Each request carries an opcode (pulse edge,
// poll update or consume tick) and the current microsecond time, and gives
// exactly one result: whether a tick was granted, the sync flag, the smoothed
// period, tempo times 256 and the pending tick count. Requests are handled
// one at a time. Pulse, consume and unused opcodes pass from acceptance
// through the gap, execute and result states; a poll that folds in a new
// interval also waits on the shared iterative unit for the moving-average
// multiply and the tempo division, and a poll with no new interval goes
// through the timeout check. The next request is accepted once the result
// has been written to the output register, even while that result waits to
// be taken. The user must write configuration registers through cfg_we,
// cfg_idx and cfg_wdata only while the block is idle; it is not enforced.
module external_clock_tempo_tracker_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ectt_in_if.sink                              in_ch,
	ectt_out_if.source                           out_ch,
	input  logic                                 cfg_we,
	input  logic [ectt_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [ectt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	// Configuration registers.
	logic [31:0]                      glitch_q;
	logic [31:0]                      timeout_q;
	logic [7:0]                       max_pnd_q;
	logic [ectt_pkg::ALPHA_W-1:0]     alpha_q;
	logic [6:0]                       ppq_q;

	// Tracker state.
	logic [63:0]                      last_q;
	logic [31:0]                      cap_q;
	logic                             fresh_q;
	logic [7:0]                       pend_q;
	logic [31:0]                      period_q;
	logic [23:0]                      tempo_q;
	logic                             sync_q;

	// Request and working registers.
	ectt_pkg::state_t                 state_q;
	ectt_pkg::state_t                 state_d;
	logic [1:0]                       op_q;
	logic [63:0]                      now_q;
	logic [63:0]                      gap_q;
	logic                             neg_q;
	logic [ectt_pkg::MAG_W-1:0]       mag_q;
	logic [ectt_pkg::PROD_W-1:0]      prod_q;
	logic [ectt_pkg::DVS_W-1:0]       dvs_q;
	logic                             grant_q;

	// Result register.
	logic                             out_valid_q;
	logic                             out_grant_q;
	logic                             out_sync_q;
	logic [31:0]                      out_period_q;
	logic [23:0]                      out_tempo_q;
	logic [7:0]                       out_pend_q;

	logic                             in_acc;
	logic                             out_free;
	logic                             out_load;
	logic [31:0]                      sample;
	logic [32:0]                      diff;
	logic [32:0]                      step;
	logic [33:0]                      blend_up;
	logic [33:0]                      blend_dn;
	logic                             glitch_hit;
	logic                             seen;
	ectt_pkg::alu_req_t               alu_req;
	ectt_pkg::alu_sts_t               alu_sts;
	logic [ectt_pkg::PROD_W-1:0]      alu_prod;
	logic [ectt_pkg::QUO_W-1:0]       alu_quo;

	ectt_alu u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (alu_req),
		.mul_a    (mag_q),
		.mul_b    (alpha_q),
		.div_d    (dvs_q),
		.sts      (alu_sts),
		.product  (alu_prod),
		.quotient (alu_quo)
	);

	// Arithmetic shared by the sequencer states.
	always_comb begin
		sample     = fresh_q ? cap_q : 32'd0;
		diff       = {1'b0, sample} - {1'b0, period_q};
		step       = prod_q[ectt_pkg::PROD_W-1:16];
		blend_up   = {2'b00, period_q} + {1'b0, step};
		blend_dn   = {2'b00, period_q} - {1'b0, step};
		seen       = (last_q != 64'd0);
		glitch_hit = seen && (gap_q < {32'd0, glitch_q});
		in_acc     = in_ch.valid && in_ch.ready;
		out_free   = !out_valid_q || out_ch.ready;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ectt_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = ectt_pkg::ST_GAP;
				end
			end
			ectt_pkg::ST_GAP: state_d = ectt_pkg::ST_EXEC;
			ectt_pkg::ST_EXEC: begin
				if (op_q == ectt_pkg::OP_POLL) begin
					if (sample == 32'd0) begin
						state_d = ectt_pkg::ST_TIMEOUT;
					end else if (period_q == 32'd0) begin
						state_d = ectt_pkg::ST_DVS;
					end else begin
						state_d = ectt_pkg::ST_MUL_WAIT;
					end
				end else begin
					state_d = ectt_pkg::ST_OUT;
				end
			end
			ectt_pkg::ST_MUL_WAIT: begin
				if (alu_sts.done) begin
					state_d = ectt_pkg::ST_BLEND;
				end
			end
			ectt_pkg::ST_BLEND: state_d = ectt_pkg::ST_DVS;
			ectt_pkg::ST_DVS: state_d = ectt_pkg::ST_DIV_GO;
			ectt_pkg::ST_DIV_GO: begin
				state_d = (dvs_q == '0) ? ectt_pkg::ST_TIMEOUT : ectt_pkg::ST_DIV_WAIT;
			end
			ectt_pkg::ST_DIV_WAIT: begin
				if (alu_sts.done) begin
					state_d = ectt_pkg::ST_TEMPO;
				end
			end
			ectt_pkg::ST_TEMPO: state_d = ectt_pkg::ST_TIMEOUT;
			ectt_pkg::ST_TIMEOUT: state_d = ectt_pkg::ST_OUT;
			ectt_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = ectt_pkg::ST_IDLE;
				end
			end
			default: state_d = ectt_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ch.ready   = (state_q == ectt_pkg::ST_IDLE);
		out_load      = (state_q == ectt_pkg::ST_OUT) && out_free;
		alu_req.start = 1'b0;
		alu_req.op    = ectt_pkg::ALU_MUL;
		case (state_q)
			ectt_pkg::ST_MUL_WAIT: begin
				alu_req.start = !alu_sts.busy && !alu_sts.done;
				alu_req.op    = ectt_pkg::ALU_MUL;
			end
			ectt_pkg::ST_DIV_GO: begin
				alu_req.start = (dvs_q != '0);
				alu_req.op    = ectt_pkg::ALU_DIV;
			end
			default: begin
				alu_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ectt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glitch_q  <= ectt_pkg::GLITCH_RST;
			timeout_q <= ectt_pkg::TIMEOUT_RST;
			max_pnd_q <= ectt_pkg::MAX_PND_RST;
			alpha_q   <= ectt_pkg::ALPHA_RST;
			ppq_q     <= ectt_pkg::PPQ_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				ectt_pkg::CFG_GLITCH:  glitch_q  <= cfg_wdata;
				ectt_pkg::CFG_TIMEOUT: timeout_q <= cfg_wdata;
				ectt_pkg::CFG_MAX_PND: max_pnd_q <= cfg_wdata[7:0];
				ectt_pkg::CFG_ALPHA:   alpha_q   <= cfg_wdata[ectt_pkg::ALPHA_W-1:0];
				ectt_pkg::CFG_PPQ:     ppq_q     <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// Tracker state updates, chosen by sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			cap_q    <= '0;
			fresh_q  <= 1'b0;
			pend_q   <= '0;
			period_q <= '0;
			tempo_q  <= '0;
			sync_q   <= 1'b0;
			grant_q  <= 1'b0;
		end else begin
			case (state_q)
				ectt_pkg::ST_IDLE: begin
					grant_q <= 1'b0;
				end
				ectt_pkg::ST_EXEC: begin
					case (op_q)
						ectt_pkg::OP_PULSE: begin
							if (!glitch_hit) begin
								if (seen && (gap_q < {32'd0, timeout_q})) begin
									cap_q   <= gap_q[31:0];
									fresh_q <= 1'b1;
									if (pend_q < max_pnd_q) begin
										pend_q <= pend_q + 8'd1;
									end
								end
								last_q <= now_q;
							end
						end
						ectt_pkg::OP_POLL: begin
							fresh_q <= 1'b0;
							// The first interval seeds the average.
							if ((sample != 32'd0) && (period_q == 32'd0)) begin
								period_q <= sample;
							end
						end
						ectt_pkg::OP_CONSUME: begin
							if (pend_q != 8'd0) begin
								pend_q  <= pend_q - 8'd1;
								grant_q <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				ectt_pkg::ST_BLEND: begin
					// Move towards the sample, clamped to the period range.
					if (neg_q) begin
						period_q <= blend_dn[33] ? 32'd0 : blend_dn[31:0];
					end else begin
						period_q <= (blend_up[33:32] != 2'b00) ? 32'hFFFFFFFF : blend_up[31:0];
					end
				end
				ectt_pkg::ST_DIV_GO: begin
					if (dvs_q == '0) begin
						tempo_q <= ectt_pkg::TEMPO_MAX;
						sync_q  <= 1'b1;
					end
				end
				ectt_pkg::ST_TEMPO: begin
					tempo_q <= (alu_quo[ectt_pkg::QUO_W-1:24] != '0) ? ectt_pkg::TEMPO_MAX
						: alu_quo[23:0];
					sync_q  <= 1'b1;
				end
				ectt_pkg::ST_TIMEOUT: begin
					// Silence on the external clock drops sync.
					if (sync_q && (gap_q > {32'd0, timeout_q})) begin
						sync_q   <= 1'b0;
						period_q <= '0;
						pend_q   <= '0;
						fresh_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers without reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= in_ch.opcode;
			now_q <= in_ch.now_us;
		end
		if (state_q == ectt_pkg::ST_GAP) begin
			gap_q <= now_q - last_q;
		end
		if (state_q == ectt_pkg::ST_EXEC) begin
			neg_q <= diff[32];
			mag_q <= diff[32] ? (~diff[31:0] + 32'd1) : diff[31:0];
		end
		if ((state_q == ectt_pkg::ST_MUL_WAIT) && alu_sts.done) begin
			prod_q <= alu_prod;
		end
		if (state_q == ectt_pkg::ST_DVS) begin
			dvs_q <= ectt_pkg::DVS_W'(period_q) * ectt_pkg::DVS_W'(ppq_q);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_grant_q  <= grant_q;
			out_sync_q   <= sync_q;
			out_period_q <= period_q;
			out_tempo_q  <= tempo_q;
			out_pend_q   <= pend_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.tick_granted  = out_grant_q;
	assign out_ch.ext_sync      = out_sync_q;
	assign out_ch.period_us     = out_period_q;
	assign out_ch.bpm_q8        = out_tempo_q;
	assign out_ch.pending_ticks = out_pend_q;

	// The shared unit is never running while a new request can be taken.
	a_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !alu_sts.busy)
		else $error("arithmetic unit busy while accepting a request");

	// A completion only arrives while the sequencer waits for one.
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_sts.done |-> (state_q == ectt_pkg::ST_MUL_WAIT || state_q == ectt_pkg::ST_DIV_WAIT))
		else $error("arithmetic unit finished outside a wait state");

	// Leaving the result state always presents a result.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_ch.valid)
		else $error("result lost after loading");

	// Only one request is in flight: no acceptance while a request is worked on.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ch.ready)
		else $error("request accepted while another is in progress");

endmodule

>>> rtl/core/ectt_alu.sv
// Shared iterative unit: shift-and-add multiply, one multiplier bit per cycle,
// and restoring division of the tempo constant, one quotient bit per cycle.
// Both use the same wide adder.
module ectt_alu (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ectt_pkg::alu_req_t                req,
	input  logic [ectt_pkg::MAG_W-1:0]        mul_a,
	input  logic [ectt_pkg::ALPHA_W-1:0]      mul_b,
	input  logic [ectt_pkg::DVS_W-1:0]        div_d,
	output ectt_pkg::alu_sts_t                sts,
	output logic [ectt_pkg::PROD_W-1:0]       product,
	output logic [ectt_pkg::QUO_W-1:0]        quotient
);

	logic                              busy_q;
	logic                              done_q;
	ectt_pkg::alu_op_t                 op_q;
	logic [ectt_pkg::CNT_W-1:0]        cnt_q;
	logic [ectt_pkg::PROD_W-1:0]       acc_q;
	logic [ectt_pkg::PROD_W-1:0]       mc_q;
	logic [ectt_pkg::ALPHA_W-1:0]      mp_q;
	logic [ectt_pkg::DVS_W-1:0]        rem_q;
	logic [ectt_pkg::QUO_W-1:0]        num_q;
	logic [ectt_pkg::DVS_W-1:0]        dvs_q;

	logic [ectt_pkg::DVS_W:0]          shifted;
	logic [ectt_pkg::ADD_W-1:0]        add_x;
	logic [ectt_pkg::ADD_W-1:0]        add_y;
	logic                              add_cin;
	logic [ectt_pkg::ADD_W-1:0]        sum;
	logic                              neg;

	// Operand selection for the shared adder.
	always_comb begin
		shifted = {rem_q, num_q[ectt_pkg::QUO_W-1]};
		if (op_q == ectt_pkg::ALU_DIV) begin
			add_x   = ectt_pkg::ADD_W'(shifted);
			add_y   = ~(ectt_pkg::ADD_W'(dvs_q));
			add_cin = 1'b1;
		end else begin
			add_x   = ectt_pkg::ADD_W'(acc_q);
			add_y   = ectt_pkg::ADD_W'(mc_q);
			add_cin = 1'b0;
		end
		sum = add_x + add_y + ectt_pkg::ADD_W'(add_cin);
		neg = sum[ectt_pkg::ADD_W-1];
	end

	// Control: step counter and busy and done flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ectt_pkg::ALU_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == ectt_pkg::ALU_DIV) ? ectt_pkg::DIV_LAST : ectt_pkg::MUL_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: load operands on start, then one step per cycle.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			acc_q <= '0;
			mc_q  <= ectt_pkg::PROD_W'(mul_a);
			mp_q  <= mul_b;
			rem_q <= '0;
			num_q <= ectt_pkg::TEMPO_NUM;
			dvs_q <= div_d;
		end else if (busy_q) begin
			if (op_q == ectt_pkg::ALU_DIV) begin
				rem_q <= neg ? shifted[ectt_pkg::DVS_W-1:0] : sum[ectt_pkg::DVS_W-1:0];
				num_q <= {num_q[ectt_pkg::QUO_W-2:0], ~neg};
			end else begin
				if (mp_q[0]) begin
					acc_q <= sum[ectt_pkg::PROD_W-1:0];
				end
				mc_q <= {mc_q[ectt_pkg::PROD_W-2:0], 1'b0};
				mp_q <= {1'b0, mp_q[ectt_pkg::ALPHA_W-1:1]};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = acc_q;
	assign quotient = num_q;

endmodule
